[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

[hw/rtl/nna_pkg.sv]
`default_nettype none

package nna_pkg;

  localparam int DataW    = 16;
  localparam int FracBits = 12;
  localparam int Segments = 64;
  localparam int Knots    = Segments + 1;
  localparam int KnotW    = FracBits;
  localparam int KnotIdxW = $clog2(Knots);
  localparam int SegW     = $clog2(Segments);
  localparam int SpanW    = FracBits + 3;
  localparam int SegOffW  = SpanW - SegW;
  localparam int DeltaW   = 8;
  localparam int ProdW    = 2 * KnotW;
  localparam int Stages   = 5;
  localparam int OneQ     = 1 << FracBits;

  typedef enum logic [1:0] {
    ActIdentity = 2'd0,
    ActSigmoid  = 2'd1,
    ActTanh     = 2'd2,
    ActRelu     = 2'd3
  } act_kind_e;

  typedef struct packed {
    logic             func;
    act_kind_e        kind;
    logic             neg;
    logic             pos;
    logic [DataW-1:0] x;
  } nna_side_t;

  // Sigmoid at t = 8k/Segments, rounded to FracBits fraction bits.
  localparam logic [KnotW-1:0] KnotTable [Knots] = '{
    12'd2048, 12'd2176, 12'd2303, 12'd2428, 12'd2550, 12'd2668, 12'd2782, 12'd2891,
    12'd2994, 12'd3092, 12'd3184, 12'd3269, 12'd3349, 12'd3422, 12'd3490, 12'd3551,
    12'd3608, 12'd3659, 12'd3705, 12'd3747, 12'd3785, 12'd3819, 12'd3850, 12'd3877,
    12'd3902, 12'd3924, 12'd3943, 12'd3960, 12'd3976, 12'd3990, 12'd4002, 12'd4013,
    12'd4022, 12'd4031, 12'd4038, 12'd4045, 12'd4051, 12'd4056, 12'd4061, 12'd4065,
    12'd4069, 12'd4072, 12'd4075, 12'd4077, 12'd4079, 12'd4081, 12'd4083, 12'd4085,
    12'd4086, 12'd4087, 12'd4088, 12'd4089, 12'd4090, 12'd4091, 12'd4091, 12'd4092,
    12'd4092, 12'd4093, 12'd4093, 12'd4093, 12'd4094, 12'd4094, 12'd4094, 12'd4094,
    12'd4095
  };

endpackage

`default_nettype wire

[hw/rtl/nn_activation_unit.sv]
// Elementwise activation: identity, sigmoid, tanh or ReLU on one signed
// Q4.12 value, or the derivative when func_i is set (identity ignores it).
// Input channel: in_valid_i / in_ready_o carrying func_i, act_kind_i and
// x_value_i. Output channel: out_valid_o / out_ready_i carrying y_value_o.
// Stages from acceptance to out_valid_o: magnitude and segment select,
// knot table read, interpolation multiply, result multiply, rounding into
// the output register. Throughput is one transaction per cycle unless the
// pipe backs up; each stage holds one transaction behind its own valid bit.
// Reset clears every valid bit, so the pipe comes up empty and ready.
// When the receiver stalls, the output register holds its transaction and
// the stages behind it keep filling until all five are occupied; only then
// does in_ready_o drop. Empty stages are squeezed out while stalled.
`default_nettype none
`include "assert_macros.svh"

module nn_activation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [1:0]                       act_kind_i,
  input  logic signed [nna_pkg::DataW-1:0] x_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [nna_pkg::DataW-1:0] y_value_o
);
  import nna_pkg::*;

  logic [Stages-1:0]  vld_d;
  logic [Stages-1:0]  vld_q;
  logic [Stages-1:0]  vld_in;
  logic [Stages:0]    rdy;
  logic [Stages-1:0]  en;

  nna_side_t          side2;
  logic [KnotW-1:0]   lo2;
  logic [DeltaW-1:0]  delta2;
  logic [SegOffW-1:0] offs2;
  nna_side_t          side3;
  logic [KnotW-1:0]   sig3;
  logic [DataW-1:0]   y5;

  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int i = Stages - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_in = {vld_q[Stages-2:0], in_valid_i};
    en     = vld_in & rdy[Stages-1:0];
    for (int i = 0; i < Stages; i++) begin
      vld_d[i] = rdy[i] ? vld_in[i] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  nna_front u_front (
    .clk_i      (clk_i),
    .en_i       (en[1:0]),
    .func_i     (func_i),
    .act_kind_i (act_kind_i),
    .x_value_i  (x_value_i),
    .side_o     (side2),
    .lo_o       (lo2),
    .delta_o    (delta2),
    .offs_o     (offs2)
  );

  nna_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[2]),
    .side_i  (side2),
    .lo_i    (lo2),
    .delta_i (delta2),
    .offs_i  (offs2),
    .side_o  (side3),
    .sig_o   (sig3)
  );

  nna_back u_back (
    .clk_i  (clk_i),
    .en_i   (en[4:3]),
    .side_i (side3),
    .sig_i  (sig3),
    .y_o    (y5)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign y_value_o   = $signed(y5);

  `ASSERT_PROP(ready_when_drained, clk_i, rst_ni, out_ready_i |-> in_ready_o)
  `ASSERT_PROP(ready_when_out_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `ASSERT_PROP(accept_fills_first, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> vld_q[0])
  `ASSERT_NEVER(full_pipe_ready, clk_i, rst_ni, (&vld_q) && !out_ready_i && in_ready_o)

endmodule

`default_nettype wire

[hw/rtl/nna_front.sv]
`default_nettype none

module nna_front (
  input  logic                                clk_i,
  input  logic [1:0]                          en_i,
  input  logic                                func_i,
  input  logic [1:0]                          act_kind_i,
  input  logic signed [nna_pkg::DataW-1:0]    x_value_i,
  output nna_pkg::nna_side_t                  side_o,
  output logic [nna_pkg::KnotW-1:0]           lo_o,
  output logic [nna_pkg::DeltaW-1:0]          delta_o,
  output logic [nna_pkg::SegOffW-1:0]         offs_o
);
  import nna_pkg::*;

  logic                 neg;
  logic [DataW:0]       ext;
  logic [DataW:0]       abs_val;
  logic [DataW+1:0]     mag;
  nna_side_t            side1_d;
  nna_side_t            side1_q;
  logic                 sat1_d;
  logic                 sat1_q;
  logic [SegW-1:0]      seg1_q;
  logic [SegOffW-1:0]   offs1_q;
  logic [KnotIdxW-1:0]  idx_lo;
  logic [KnotIdxW-1:0]  idx_hi;
  logic [KnotW-1:0]     lo2_d;
  logic [KnotW-1:0]     hi2_d;
  nna_side_t            side2_q;
  logic [KnotW-1:0]     lo2_q;
  logic [DeltaW-1:0]    delta2_q;
  logic [SegOffW-1:0]   offs2_q;

  always_comb begin
    neg          = x_value_i[DataW-1];
    ext          = {x_value_i[DataW-1], x_value_i};
    abs_val      = neg ? (~ext + {{DataW{1'b0}}, 1'b1}) : ext;
    side1_d.func = func_i;
    side1_d.kind = act_kind_e'(act_kind_i);
    side1_d.neg  = neg;
    side1_d.pos  = !neg && (x_value_i != '0);
    side1_d.x    = x_value_i;
    // tanh looks the curve up at twice the magnitude
    mag          = (side1_d.kind == ActTanh) ? {abs_val, 1'b0} : {1'b0, abs_val};
    sat1_d       = |mag[DataW+1:SpanW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side1_q <= side1_d;
      sat1_q  <= sat1_d;
      seg1_q  <= mag[SpanW-1:SegOffW];
      offs1_q <= mag[SegOffW-1:0];
    end
  end

  always_comb begin
    idx_lo = KnotIdxW'(seg1_q);
    idx_hi = idx_lo + KnotIdxW'(1);
    if (sat1_q) begin
      lo2_d = KnotTable[Segments];
      hi2_d = KnotTable[Segments];
    end else begin
      lo2_d = KnotTable[idx_lo];
      hi2_d = KnotTable[idx_hi];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side2_q  <= side1_q;
      lo2_q    <= lo2_d;
      delta2_q <= DeltaW'(hi2_d - lo2_d);
      offs2_q  <= offs1_q;
    end
  end

  assign side_o  = side2_q;
  assign lo_o    = lo2_q;
  assign delta_o = delta2_q;
  assign offs_o  = offs2_q;

endmodule

`default_nettype wire

[hw/rtl/nna_interp.sv]
`default_nettype none
`include "assert_macros.svh"

module nna_interp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  nna_pkg::nna_side_t          side_i,
  input  logic [nna_pkg::KnotW-1:0]   lo_i,
  input  logic [nna_pkg::DeltaW-1:0]  delta_i,
  input  logic [nna_pkg::SegOffW-1:0] offs_i,
  output nna_pkg::nna_side_t          side_o,
  output logic [nna_pkg::KnotW-1:0]   sig_o
);
  import nna_pkg::*;

  localparam int MulW = DeltaW + SegOffW;

  logic [MulW-1:0]   prod;
  logic [MulW-1:0]   sum;
  logic [KnotW-1:0]  sig_d;
  logic [KnotW-1:0]  sig_q;
  nna_side_t         side_q;

  always_comb begin
    prod  = MulW'(delta_i) * MulW'(offs_i);
    sum   = prod + MulW'(1 << (SegOffW - 1));
    sig_d = lo_i + KnotW'(sum[MulW-1:SegOffW]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sig_q  <= sig_d;
      side_q <= side_i;
    end
  end

  assign sig_o  = sig_q;
  assign side_o = side_q;

  `ASSERT_PROP(sig_upper_half, clk_i, rst_ni, $past(en_i) |-> sig_q[KnotW-1])

endmodule

`default_nettype wire

[hw/rtl/nna_back.sv]
`default_nettype none

module nna_back (
  input  logic                       clk_i,
  input  logic [1:0]                 en_i,
  input  nna_pkg::nna_side_t         side_i,
  input  logic [nna_pkg::KnotW-1:0]  sig_i,
  output logic [nna_pkg::DataW-1:0]  y_o
);
  import nna_pkg::*;

  logic [KnotW-1:0]  one_minus;
  logic [KnotW:0]    twice;
  logic [KnotW-1:0]  tnh;
  logic [KnotW-1:0]  op_a;
  logic [KnotW-1:0]  op_b;
  logic [DataW-1:0]  cand_d;
  logic [DataW-1:0]  cand_q;
  logic [ProdW-1:0]  prod_q;
  logic              func_q;
  act_kind_e         kind_q;
  logic [ProdW-1:0]  rnd_sum;
  logic [KnotW-1:0]  rnd;
  logic [DataW-1:0]  y_d;
  logic [DataW-1:0]  y_q;

  always_comb begin
    one_minus = KnotW'((KnotW+1)'(OneQ) - (KnotW+1)'(sig_i));
    twice     = {sig_i, 1'b0};
    tnh       = KnotW'(twice - (KnotW+1)'(OneQ));
    op_a      = (side_i.kind == ActTanh) ? tnh : sig_i;
    op_b      = (side_i.kind == ActTanh) ? tnh : one_minus;
    case (side_i.kind)
      ActIdentity: cand_d = side_i.x;
      ActSigmoid:  cand_d = side_i.neg ? DataW'(one_minus) : DataW'(sig_i);
      ActTanh:     cand_d = side_i.neg ? (DataW'(0) - DataW'(tnh)) : DataW'(tnh);
      ActRelu: begin
        if (!side_i.pos) begin
          cand_d = '0;
        end else begin
          cand_d = side_i.func ? DataW'(OneQ) : side_i.x;
        end
      end
      default:     cand_d = side_i.x;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= ProdW'(op_a) * ProdW'(op_b);
      cand_q <= cand_d;
      func_q <= side_i.func;
      kind_q <= side_i.kind;
    end
  end

  always_comb begin
    rnd_sum = prod_q + ProdW'(OneQ >> 1);
    rnd     = rnd_sum[ProdW-1:FracBits];
    y_d     = cand_q;
    if (func_q) begin
      case (kind_q)
        ActSigmoid: y_d = DataW'(rnd);
        ActTanh:    y_d = DataW'(OneQ) - DataW'(rnd);
        default:    y_d = cand_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire
